// ----- design/isrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_pkg: shared types and constants of the insertion sorter
// Holds the data width, the default capacity and the structs that travel
// between the sorter cells and the top level.
// ----------------------------------------------------------------------------
package isrt_pkg;

  // Width of one sorted element.
  localparam int DATA_W = 32;

  // Default capacity of the sorter chain.
  localparam int MAX_ITEMS_DEF = 64;

  // Command broadcast to every cell in a cycle.
  typedef struct packed {
    logic insert;  // place the broadcast value, larger entries move up
    logic shift;   // every entry moves one cell toward the output
  } cell_ctrl_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic                     valid;  // the cell holds an entry
    logic                     gt;     // entry is greater than the broadcast value
    logic signed [DATA_W-1:0] data;   // the entry itself
  } cell_link_t;

endpackage

// ----- design/isrt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_in_if / isrt_out_if: valid-ready channels of the insertion sorter
// The input channel carries one element and its last flag; the output channel
// carries one sorted element with its final and overflow flags.
// ----------------------------------------------------------------------------
interface isrt_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [isrt_pkg::DATA_W-1:0] value;
  logic                              last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface isrt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [isrt_pkg::DATA_W-1:0] sorted_value;
  logic                              final_res;
  logic                              overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input final_res, input overflow,
                output ready);
endinterface

// ----- design/isrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_cell: one storage cell of the insertion chain
// Holds one entry, compares it against the broadcast value, and takes either
// the value, its lower neighbor's entry or its upper neighbor's entry.
// ----------------------------------------------------------------------------
module isrt_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  isrt_pkg::cell_ctrl_t               ctrl,
  input  logic signed [isrt_pkg::DATA_W-1:0] value,
  input  isrt_pkg::cell_link_t               lower,
  input  isrt_pkg::cell_link_t               upper,
  output isrt_pkg::cell_link_t               link
);

  logic                               valid_r;
  logic                               valid_nxt;
  logic signed [isrt_pkg::DATA_W-1:0] data_r;
  logic signed [isrt_pkg::DATA_W-1:0] data_nxt;
  logic                               gt;
  logic                               take;

  // Only strictly greater entries move up, so equal keys keep arrival order.
  assign gt = valid_r && (data_r > value);

  // An occupied cell takes a new entry when it must move up; an empty cell
  // takes one when it is the first empty place of the chain.
  assign take = valid_r ? gt : lower.valid;

  // Next entry: insertion, shift toward the output, or hold.
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl.shift) begin
      valid_nxt = upper.valid;
      data_nxt  = upper.data;
    end else if (ctrl.insert && take) begin
      valid_nxt = 1'b1;
      data_nxt  = lower.gt ? lower.data : value;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign link.data  = data_r;

endmodule

// ----- design/insertion_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter: stable streaming insertion sort of signed 32-bit values
//
// Elements arrive on in_ch, one per transfer. Each element is placed in a
// chain of MAX_ITEMS cells in the same cycle: every cell compares its entry
// with the arriving value, and entries strictly greater move up one cell, so
// equal keys keep their arrival order. While the set is being collected the
// block takes one element every cycle.
// An element flagged last is inserted too, and the block then drains the
// chain through out_ch in ascending order, one element per cycle while the
// receiver is ready, starting the cycle after that transfer. Input is held
// off (in_ch.ready low) until the final element, which carries final_res,
// has been transferred.
// Elements arriving while the chain is full are dropped; every result of that
// set then carries overflow.
// When the receiver stalls, the lowest cell simply holds its entry on out_ch.
// Reset clears all occupancy flags at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module insertion_sorter #(
  parameter int MAX_ITEMS = isrt_pkg::MAX_ITEMS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  isrt_in_if.sink          in_ch,
  isrt_out_if.source       out_ch
);

  isrt_pkg::cell_ctrl_t ctrl;
  isrt_pkg::cell_link_t link [MAX_ITEMS];
  isrt_pkg::cell_link_t bottom_link;
  isrt_pkg::cell_link_t top_link;

  logic flush_r;
  logic flush_nxt;
  logic dropped_r;
  logic dropped_nxt;
  logic in_fire;
  logic out_fire;
  logic full;
  logic final_out;

  // Handshakes.
  assign in_ch.ready = !flush_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign full        = link[MAX_ITEMS-1].valid;
  assign final_out   = !link[1].valid;

  // Chain commands.
  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;

  // Boundary links: below the first cell counts as occupied and never greater,
  // above the last cell is always empty.
  assign bottom_link.valid = 1'b1;
  assign bottom_link.gt    = 1'b0;
  assign bottom_link.data  = '0;
  assign top_link.valid    = 1'b0;
  assign top_link.gt       = 1'b0;
  assign top_link.data     = '0;

  // Row of cells.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isrt_pkg::cell_link_t lower;
    isrt_pkg::cell_link_t upper;

    if (i == 0) begin : g_first
      assign lower = bottom_link;
    end else begin : g_lower
      assign lower = link[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign upper = top_link;
    end else begin : g_upper
      assign upper = link[i+1];
    end

    isrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .value (in_ch.value),
      .lower (lower),
      .upper (upper),
      .link  (link[i])
    );
  end

  // Flush and overflow tracking.
  always_comb begin
    flush_nxt   = flush_r;
    dropped_nxt = dropped_r;
    if (in_fire) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_ch.last) begin
        flush_nxt = 1'b1;
      end
    end else if (out_fire && final_out) begin
      flush_nxt   = 1'b0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r   <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      flush_r   <= flush_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // The lowest cell drives the output transfer.
  assign out_ch.valid        = flush_r;
  assign out_ch.sorted_value = link[0].data;
  assign out_ch.final_res    = final_out;
  assign out_ch.overflow     = dropped_r;

endmodule

// ----- dv/insertion_sorter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_test: self-checking bench for the streaming insertion sorter
// A queue of element sets, filled up front, feeds a clocked driver on in_ch.
// Every accepted element goes through a shadow sorted list, and a flagged
// last element turns that list into the expected drain. A clocked monitor
// on out_ch compares each transfer with the oldest expected result. The run
// steps through four idling phases, including full sets and overflowing sets.
// ----------------------------------------------------------------------------
module insertion_sorter_test;

  localparam int DATA_W = isrt_pkg::DATA_W;
  localparam int CAP = isrt_pkg::MAX_ITEMS_DEF;
  localparam int RANDOM_ELEMS = 230;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } elem_t;

  typedef struct {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } drain_t;

  typedef enum logic [1:0] {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH
  } idle_phase_t;

  logic clk;
  logic rst_n;

  isrt_in_if  in_ch ();
  isrt_out_if out_ch ();

  elem_t                    unsent_elems[$];
  drain_t                   expected_drain[$];
  logic signed [DATA_W-1:0] shadow_list[$];
  logic                     shadow_dropped;
  int                       elems_sent;
  int                       total_elems;
  idle_phase_t              phase;
  int                       src_idle_pct;
  int                       sink_stall_pct;
  bit                       broken;

  insertion_sorter #(
    .MAX_ITEMS(CAP)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // The idling phase follows the share of elements already sent.
  always_comb begin
    case ((total_elems == 0) ? 0 : (elems_sent * 4) / total_elems)
      0: phase = PH_FREE;
      1: phase = PH_SRC_IDLE;
      2: phase = PH_SINK_STALL;
      default: phase = PH_BOTH;
    endcase
    case (phase)
      PH_FREE: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      PH_SRC_IDLE: begin
        src_idle_pct = 81;
        sink_stall_pct = 0;
      end
      PH_SINK_STALL: begin
        src_idle_pct = 0;
        sink_stall_pct = 81;
      end
      default: begin
        src_idle_pct = 26;
        sink_stall_pct = 26;
      end
    endcase
  end

  // Shadow of the sorter: a stable insert, and on a last element the whole
  // sorted list becomes expected results before the list empties.
  function automatic void sort_in(elem_t e);
    int     pos;
    drain_t r;
    if (shadow_list.size() >= CAP) begin
      // Full store: the element is lost and the set is marked.
      shadow_dropped = 1'b1;
    end else begin
      pos = shadow_list.size();
      // Only strictly greater entries move up, so equal keys keep their order.
      while (pos > 0 && shadow_list[pos-1] > e.value) pos--;
      shadow_list.insert(pos, e.value);
    end
    if (e.last) begin
      foreach (shadow_list[k]) begin
        r.sorted_value = shadow_list[k];
        r.final_res = (k == shadow_list.size() - 1);
        r.overflow = shadow_dropped;
        expected_drain.push_back(r);
      end
      shadow_list.delete();
      shadow_dropped = 1'b0;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      // A narrow range around zero gives many equal keys.
      2, 3: return int'($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_set(logic signed [DATA_W-1:0] vals[$]);
    elem_t e;
    foreach (vals[i]) begin
      e.value = vals[i];
      e.last = (i == vals.size() - 1);
      unsent_elems.push_back(e);
    end
  endfunction

  // Driver: a new element is offered once the current one has transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      elems_sent <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sort_in('{value: in_ch.value, last: in_ch.last});
        elems_sent <= elems_sent + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (unsent_elems.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= unsent_elems[0].value;
          in_ch.last <= unsent_elems[0].last;
          unsent_elems.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every output transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_drain.size() == 0) begin
          $error("unexpected result: sorted_value %0d", out_ch.sorted_value);
          broken = 1'b1;
        end else begin
          if (out_ch.sorted_value !== expected_drain[0].sorted_value) begin
            $error("sorted_value: expected %0d, got %0d",
                   expected_drain[0].sorted_value, out_ch.sorted_value);
            broken = 1'b1;
          end
          if (out_ch.final_res !== expected_drain[0].final_res) begin
            $error("final_res: expected %0b, got %0b",
                   expected_drain[0].final_res, out_ch.final_res);
            broken = 1'b1;
          end
          if (out_ch.overflow !== expected_drain[0].overflow) begin
            $error("overflow: expected %0b, got %0b",
                   expected_drain[0].overflow, out_ch.overflow);
            broken = 1'b1;
          end
          expected_drain.pop_front();
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    logic signed [DATA_W-1:0] vals[$];
    int n_random;
    int set_idx;
    int full_at;
    int over_at;
    int set_len;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    broken = 1'b0;
    shadow_dropped = 1'b0;
    total_elems = 0;

    // Directed sets: single elements, extremes, equal keys, both orders.
    add_set('{0});
    add_set('{VAL_MAX});
    add_set('{VAL_MIN});
    add_set('{VAL_MAX, VAL_MIN, 0, -1, 1});
    add_set('{5, 5, 5});
    add_set('{3, 2, 1, 0, -1, -2});
    add_set('{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN});

    // Random sets: mostly short, one that exactly fills the store and one
    // that overflows it, so that its last element is dropped as well.
    n_random = 0;
    set_idx = 0;
    full_at = $urandom_range(2, 6);
    over_at = $urandom_range(8, 14);
    while (n_random < RANDOM_ELEMS || set_idx <= over_at) begin
      if (set_idx == full_at) set_len = CAP;
      else if (set_idx == over_at) set_len = CAP + $urandom_range(1, 4);
      else set_len = $urandom_range(1, 10);
      vals.delete();
      repeat (set_len) vals.push_back(pick_value());
      add_set(vals);
      n_random += set_len;
      set_idx++;
    end
    total_elems = unsent_elems.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (unsent_elems.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_drain.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (!broken) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
